### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the linear key/value table
// Request and response payloads, operation and status codes, sequencer
// states and the default sizes handed to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  // Fixed port widths
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int LIMIT_W = 5;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  // Capacity limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Widest stored value
  localparam int MAX_VALUE_W = 64;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  // Status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EXISTS  = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  // Request payload
  typedef struct packed {
    mode_t              mode;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]  write_value;
  } req_t;

  // Response payload
  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_COMPARE,
    SQ_APPEND,
    SQ_SHIFT_READ,
    SQ_SHIFT_WRITE,
    SQ_DONE
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/linear_key_value_table.sv
// ----------------------------------------------------------------------------
// linear_key_value_table: small associative key/value table
// Entries stay packed in insertion order; add, update, get and remove
// find their key by a linear search from the first entry.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  lkv_pkg::req_t
//   rsp       out        rsp_valid / rsp_ready  lkv_pkg::rsp_t
//   cfg       in         cfg_we                 capacity limit, 5 bits
//
// A request visits the single key comparator once per entry searched
// (a RAM read state, then a compare state), runs a shift-read and a
// shift-write state per entry shifted down on remove, and passes through
// the accept, append (on add) and done steps. Searched plus shifted
// entries never exceed the count. req_ready is high only while the
// sequencer is idle. A finished response waits in the output register; the
// next request is taken meanwhile, but its own response stalls the
// sequencer until the register frees. Reset is synchronous and clears the
// entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table #(
  parameter int TABLE_DEPTH = lkv_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = lkv_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lkv_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire lkv_pkg::req_t                req,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output lkv_pkg::rsp_t                     rsp
);

  import lkv_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [LIMIT_W-1:0]     capacity_limit;
  logic                   key_we;
  logic                   val_we;
  logic [IDX_W-1:0]       waddr;
  logic [IDX_W-1:0]       raddr;
  logic [KEY_W-1:0]       key_wdata;
  logic [KEY_W-1:0]       key_rdata;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [VALUE_WIDTH-1:0] val_rdata;

  // Capacity limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // Key and value stores
  lkv_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  lkv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // Search and shift sequencer
  lkv_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .capacity_limit (capacity_limit),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .key_we         (key_we),
    .val_we         (val_we),
    .waddr          (waddr),
    .raddr          (raddr),
    .key_wdata      (key_wdata),
    .key_rdata      (key_rdata),
    .val_wdata      (val_wdata),
    .val_rdata      (val_rdata)
  );

endmodule

`default_nettype wire

### rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lkv_engine.sv
// ----------------------------------------------------------------------------
// lkv_engine: search and shift sequencer
// Walks the packed entries one at a time with a single key comparator,
// then appends, overwrites, reads or shifts entries down as the request
// asks, and holds the response in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [lkv_pkg::LIMIT_W-1:0]            capacity_limit,
  // request / response
  input  wire logic                                   req_valid,
  output logic                                        req_ready,
  input  wire lkv_pkg::req_t                          req,
  output logic                                        rsp_valid,
  input  wire logic                                   rsp_ready,
  output lkv_pkg::rsp_t                               rsp,
  // table memories
  output logic                                        key_we,
  output logic                                        val_we,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
  output logic [lkv_pkg::KEY_W-1:0]                   key_wdata,
  input  wire logic [lkv_pkg::KEY_W-1:0]              key_rdata,
  output logic [VALUE_WIDTH-1:0]                      val_wdata,
  input  wire logic [VALUE_WIDTH-1:0]                 val_rdata
);

  import lkv_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W1 = CNT_W + 1;
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // State and registers
  seq_state_t              state, state_next;
  mode_t                   mode_q;
  logic [KEY_W-1:0]        key_q;
  logic [VALUE_WIDTH-1:0]  val_q;
  logic [IDX_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        count, count_next;
  status_t                 status_q, status_next;
  logic [DATA_W-1:0]       rd_q, rd_next;

  // Derived conditions
  logic                    accept;
  logic                    full;
  logic                    hit;
  logic                    last;
  logic                    more_shift;
  logic                    more_after_hit;
  logic                    rsp_load;
  logic [MAX_VALUE_W-1:0]  wv_ext;
  logic [MAX_VALUE_W-1:0]  rd_ext;
  logic [CMP_W-1:0]        count_ext;
  logic [IDX_W-1:0]        idx_inc;

  assign accept    = req_valid && req_ready;
  assign count_ext = CMP_W'(count);
  assign full      = (count == CNT_W'(TABLE_DEPTH)) || (count_ext >= CMP_W'(capacity_limit));
  assign hit       = (key_rdata == key_q);
  assign last      = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign more_after_hit = ((CNT_W'(idx) + CNT_W'(1)) < count);
  assign more_shift     = ((CNT_W1'(idx) + CNT_W1'(2)) < CNT_W1'(count));
  assign rsp_load  = (state == SQ_DONE) && (!rsp_valid || rsp_ready);
  assign wv_ext    = {{(MAX_VALUE_W-DATA_W){1'b0}}, req.write_value};
  assign rd_ext    = MAX_VALUE_W'(val_rdata);
  assign idx_inc   = idx + IDX_W'(1);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_ADD && full) begin
            state_next = SQ_DONE;
          end else if (count == '0) begin
            state_next = (req.mode == MODE_ADD) ? SQ_APPEND : SQ_DONE;
          end else begin
            state_next = SQ_READ;
          end
        end
      end
      SQ_READ: begin
        state_next = SQ_COMPARE;
      end
      SQ_COMPARE: begin
        if (hit) begin
          if (mode_q == MODE_REMOVE && more_after_hit) begin
            state_next = SQ_SHIFT_READ;
          end else begin
            state_next = SQ_DONE;
          end
        end else if (last) begin
          state_next = (mode_q == MODE_ADD) ? SQ_APPEND : SQ_DONE;
        end else begin
          state_next = SQ_READ;
        end
      end
      SQ_APPEND: begin
        state_next = SQ_DONE;
      end
      SQ_SHIFT_READ: begin
        state_next = SQ_SHIFT_WRITE;
      end
      SQ_SHIFT_WRITE: begin
        state_next = more_shift ? SQ_SHIFT_READ : SQ_DONE;
      end
      SQ_DONE: begin
        if (rsp_load) begin
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  // Datapath controls and memory ports
  always_comb begin
    req_ready   = (state == SQ_IDLE);
    idx_next    = idx;
    count_next  = count;
    status_next = status_q;
    rd_next     = rd_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    waddr       = idx;
    raddr       = (state == SQ_SHIFT_READ) ? idx_inc : idx;
    key_wdata   = key_q;
    val_wdata   = val_q;
    case (state)
      SQ_IDLE: begin
        idx_next    = '0;
        rd_next     = '0;
        status_next = STAT_OK;
        if (accept) begin
          if (req.mode == MODE_ADD && full) begin
            status_next = STAT_FULL;
          end else if (count == '0 && req.mode != MODE_ADD) begin
            status_next = STAT_MISSING;
          end
        end
      end
      SQ_COMPARE: begin
        if (hit) begin
          case (mode_q)
            MODE_ADD: begin
              status_next = STAT_EXISTS;
            end
            MODE_UPDATE: begin
              val_we = 1'b1;
            end
            MODE_GET: begin
              rd_next = rd_ext[DATA_W-1:0];
            end
            MODE_REMOVE: begin
              if (!more_after_hit) begin
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              status_next = status_q;
            end
          endcase
        end else if (last) begin
          if (mode_q != MODE_ADD) begin
            status_next = STAT_MISSING;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      SQ_APPEND: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        waddr      = count[IDX_W-1:0];
        count_next = count + CNT_W'(1);
      end
      SQ_SHIFT_WRITE: begin
        // Move the entry just read one place down
        key_we    = 1'b1;
        val_we    = 1'b1;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        if (more_shift) begin
          idx_next = idx_inc;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, working registers and response register
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    status_q <= status_next;
    rd_q     <= rd_next;
    if (accept) begin
      mode_q <= req.mode;
      key_q  <= req.key;
      val_q  <= wv_ext[VALUE_WIDTH-1:0];
    end
    if (rsp_load) begin
      rsp.status      <= status_q;
      rsp.read_value  <= rd_q;
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire
